@@ src/nat_pkg.sv @@
// shared types and constants for the named atomic table
// no dependencies
package nat_pkg;

    localparam int CAPACITY    = 1023;
    localparam int NAME_CHUNKS = 7;
    localparam int SLOT_W      = 10;
    localparam int NAME_AW     = 13;
    localparam int NAME_DEPTH  = CAPACITY * NAME_CHUNKS;

    localparam logic [2:0] MODE_LOOKUP = 3'd0;
    localparam logic [2:0] MODE_READ   = 3'd1;
    localparam logic [2:0] MODE_XCHG   = 3'd2;
    localparam logic [2:0] MODE_ADD    = 3'd3;
    localparam logic [2:0] MODE_CAS    = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TOO_LONG  = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_BAD_SLOT  = 3'd4;

    typedef struct packed {
        logic [2:0]         mode;
        logic [63:0]        name_chunk;
        logic               chunk_last;
        logic               create_if_missing;
        logic [SLOT_W-1:0]  slot;
        logic signed [63:0] operand_value;
        logic signed [63:0] compare_value;
    } cmd_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [SLOT_W-1:0]  found_slot;
        logic signed [63:0] result_value;
    } rsp_t;

endpackage

@@ src/nat_ram.sv @@
// generic single-write, single-read synchronous ram, registered read data
// no dependencies
module nat_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/named_atomic_table_top.sv @@
// named atomic table: controller, name buffer and the two table memories
// depends on nat_pkg and nat_ram
//
// channel   signals          direction  notes
// command   start, busy, cmd in         transaction taken when start && !busy
// response  done, rsp        out        one-cycle strobe, cannot be stalled
//
// value operations read the value memory, then write the new value back;
// a slot at or beyond the entry count answers ST_BAD_SLOT without reading the value memory
// a non-final name chunk is only buffered; a final chunk runs name cleanup on every
// buffered chunk (a name too long answers there), then a scan of the name memory at
// one chunk per cycle, stopping at the first match, then name writes when a new
// entry is appended
// reset clears the entry count and name buffer; no clearing pass on the memories
// the receiver cannot stall; busy holds off the next command until a transaction ends
module named_atomic_table_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  nat_pkg::cmd_t cmd,
    output logic          done,
    output nat_pkg::rsp_t rsp
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_VMOD   = 3'd1;
    localparam logic [2:0] S_CANON  = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_APPEND = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [9:0]  count_reg, count_next;
    logic [63:0] buf_reg [nat_pkg::NAME_CHUNKS];
    logic [63:0] buf_next [nat_pkg::NAME_CHUNKS];
    logic [2:0]  cidx_reg, cidx_next;
    logic        ovf_reg, ovf_next;
    logic        ended_reg, ended_next;
    logic [2:0]  cc_reg, cc_next;
    logic        create_reg, create_next;
    nat_pkg::cmd_t op_reg, op_next;

    logic [9:0]  rd_e_reg, rd_e_next;
    logic [2:0]  rd_c_reg, rd_c_next;
    logic [nat_pkg::NAME_AW-1:0] rd_addr_reg, rd_addr_next;
    logic        cmp_v_reg, cmp_v_next;
    logic [9:0]  cmp_e_reg, cmp_e_next;
    logic [2:0]  cmp_c_reg, cmp_c_next;
    logic        match_reg, match_next;
    logic [nat_pkg::NAME_AW-1:0] base_reg, base_next;

    logic          done_reg, done_next;
    nat_pkg::rsp_t rsp_reg, rsp_next;

    logic        v_we, v_re, n_we, n_re;
    logic [9:0]  v_waddr, v_raddr;
    logic [63:0] v_wdata, v_rdata, n_wdata, n_rdata;
    logic [nat_pkg::NAME_AW-1:0] n_waddr;

    logic        accept;
    logic [63:0] canon_chunk;
    logic        canon_ended;
    logic        issue;
    logic        eq;
    logic [63:0] new_val;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign rsp    = rsp_reg;
    assign issue  = (rd_e_reg < count_reg);
    assign eq     = (n_rdata == buf_reg[cmp_c_reg]);

    nat_ram #(.DEPTH(nat_pkg::CAPACITY), .WIDTH(64), .AW(nat_pkg::SLOT_W)) u_value_ram (
        .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
        .re(v_re), .raddr(v_raddr), .rdata(v_rdata)
    );

    nat_ram #(.DEPTH(nat_pkg::NAME_DEPTH), .WIDTH(64), .AW(nat_pkg::NAME_AW)) u_name_ram (
        .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
        .re(n_re), .raddr(rd_addr_reg), .rdata(n_rdata)
    );

    // zero every byte after the first zero byte, one chunk per cycle
    always_comb
    begin
        logic e;
        e = ended_reg;
        canon_chunk = buf_reg[cc_reg];
        for (int b = 0; b < 8; b++)
        begin
            if (e)
            begin
                canon_chunk[b*8 +: 8] = 8'h00;
            end
            else if (canon_chunk[b*8 +: 8] == 8'h00)
            begin
                e = 1'b1;
            end
        end
        canon_ended = e;
    end

    always_comb
    begin
        case (op_reg.mode)
            nat_pkg::MODE_XCHG: new_val = op_reg.operand_value;
            nat_pkg::MODE_ADD:  new_val = v_rdata + op_reg.operand_value;
            nat_pkg::MODE_CAS:  new_val = (v_rdata == op_reg.compare_value)
                                          ? op_reg.operand_value : v_rdata;
            default:            new_val = v_rdata;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        buf_next    = buf_reg;
        cidx_next   = cidx_reg;
        ovf_next    = ovf_reg;
        ended_next  = ended_reg;
        cc_next     = cc_reg;
        create_next = create_reg;
        op_next     = op_reg;
        rd_e_next   = rd_e_reg;
        rd_c_next   = rd_c_reg;
        rd_addr_next = rd_addr_reg;
        cmp_v_next  = 1'b0;
        cmp_e_next  = cmp_e_reg;
        cmp_c_next  = cmp_c_reg;
        match_next  = match_reg;
        base_next   = base_reg;
        done_next   = 1'b0;
        rsp_next    = rsp_reg;
        v_we = 1'b0; v_waddr = op_reg.slot; v_wdata = new_val;
        v_re = 1'b0; v_raddr = cmd.slot;
        n_we = 1'b0; n_waddr = base_reg + nat_pkg::NAME_AW'(cc_reg);
        n_wdata = buf_reg[cc_reg];
        n_re = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next = cmd;
                    if (cmd.mode == nat_pkg::MODE_LOOKUP)
                    begin
                        if (cidx_reg < 3'(nat_pkg::NAME_CHUNKS))
                        begin
                            buf_next[cidx_reg] = cmd.name_chunk;
                            cidx_next = cidx_reg + 3'd1;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                        if (cmd.chunk_last)
                        begin
                            create_next = cmd.create_if_missing;
                            ended_next  = 1'b0;
                            cc_next     = 3'd0;
                            state_next  = S_CANON;
                        end
                    end
                    else if (cmd.mode inside {[nat_pkg::MODE_READ:nat_pkg::MODE_CAS]})
                    begin
                        if (cmd.slot >= count_reg)
                        begin
                            done_next = 1'b1;
                            rsp_next  = '{nat_pkg::ST_BAD_SLOT, '0, '0};
                        end
                        else
                        begin
                            v_re = 1'b1;
                            state_next = S_VMOD;
                        end
                    end
                end
            end
            S_VMOD:
            begin
                v_we = 1'b1;
                done_next = 1'b1;
                rsp_next = '{nat_pkg::ST_OK, '0,
                             (op_reg.mode == nat_pkg::MODE_ADD) ? new_val : v_rdata};
                state_next = S_IDLE;
            end
            S_CANON:
            begin
                buf_next[cc_reg] = canon_chunk;
                ended_next = canon_ended;
                cc_next = cc_reg + 3'd1;
                if (cc_reg == 3'(nat_pkg::NAME_CHUNKS - 1))
                begin
                    if (ovf_reg || !canon_ended)
                    begin
                        done_next = 1'b1;
                        rsp_next  = '{nat_pkg::ST_TOO_LONG, '0, '0};
                        buf_next  = '{default: '0};
                        cidx_next = 3'd0;
                        ovf_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_e_next = '0;
                        rd_c_next = '0;
                        rd_addr_next = '0;
                        match_next = 1'b1;
                        base_next = nat_pkg::NAME_AW'({count_reg, 3'b000})
                                    - nat_pkg::NAME_AW'(count_reg);
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // reads are issued every cycle while entries remain to read; compares use the registered read data
                if (issue)
                begin
                    n_re = 1'b1;
                    rd_addr_next = rd_addr_reg + nat_pkg::NAME_AW'(1);
                    cmp_v_next = 1'b1;
                    cmp_e_next = rd_e_reg;
                    cmp_c_next = rd_c_reg;
                    if (rd_c_reg == 3'(nat_pkg::NAME_CHUNKS - 1))
                    begin
                        rd_c_next = '0;
                        rd_e_next = rd_e_reg + 10'd1;
                    end
                    else
                    begin
                        rd_c_next = rd_c_reg + 3'd1;
                    end
                end
                if (cmp_v_reg)
                begin
                    match_next = ((cmp_c_reg == 3'd0) ? 1'b1 : match_reg) && eq;
                    if (cmp_c_reg == 3'(nat_pkg::NAME_CHUNKS - 1) && match_next)
                    begin
                        done_next = 1'b1;
                        rsp_next  = '{nat_pkg::ST_OK, cmp_e_reg, '0};
                        buf_next  = '{default: '0};
                        cidx_next = 3'd0;
                        ovf_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                end
                else if (!issue)
                begin
                    if (!create_reg || count_reg >= 10'(nat_pkg::CAPACITY))
                    begin
                        done_next = 1'b1;
                        rsp_next  = '{create_reg ? nat_pkg::ST_FULL : nat_pkg::ST_NOT_FOUND,
                                      '0, '0};
                        buf_next  = '{default: '0};
                        cidx_next = 3'd0;
                        ovf_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cc_next = 3'd0;
                        state_next = S_APPEND;
                    end
                end
            end
            S_APPEND:
            begin
                n_we = 1'b1;
                cc_next = cc_reg + 3'd1;
                if (cc_reg == 3'd0)
                begin
                    v_we = 1'b1;
                    v_waddr = count_reg;
                    v_wdata = '0;
                end
                if (cc_reg == 3'(nat_pkg::NAME_CHUNKS - 1))
                begin
                    count_next = count_reg + 10'd1;
                    done_next = 1'b1;
                    rsp_next  = '{nat_pkg::ST_OK, count_reg, '0};
                    buf_next  = '{default: '0};
                    cidx_next = 3'd0;
                    ovf_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            buf_reg   <= '{default: '0};
            cidx_reg  <= '0;
            ovf_reg   <= 1'b0;
            cmp_v_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            buf_reg   <= buf_next;
            cidx_reg  <= cidx_next;
            ovf_reg   <= ovf_next;
            cmp_v_reg <= cmp_v_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ended_reg   <= ended_next;
        cc_reg      <= cc_next;
        create_reg  <= create_next;
        op_reg      <= op_next;
        rd_e_reg    <= rd_e_next;
        rd_c_reg    <= rd_c_next;
        rd_addr_reg <= rd_addr_next;
        cmp_e_reg   <= cmp_e_next;
        cmp_c_reg   <= cmp_c_next;
        match_reg   <= match_next;
        base_reg    <= base_next;
        rsp_reg     <= rsp_next;
    end

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 10'(nat_pkg::CAPACITY))
        else $error("entry count beyond capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (done_reg && rsp_reg.status == nat_pkg::ST_OK))
        else $error("entry count moved without a completed append");

    a_vwrite_state: assert property (@(posedge clk) disable iff (!rst_n)
        v_we |-> (state_reg == S_VMOD || state_reg == S_APPEND))
        else $error("value memory written outside read-modify-write or append");

    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && state_next == S_IDLE) |=> done_reg)
        else $error("busy dropped without a response");

endmodule

@@ tb/sv/tb_named_atomic_table_top.sv @@
// testbench for named_atomic_table_top: directed and random transactions
// checked against an in-bench model of the table; depends on nat_pkg and the rtl
module tb_named_atomic_table_top;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int MAX_CHUNKS     = 9;

    typedef struct {
        logic [63:0] ch [MAX_CHUNKS];
        int          n;
    } name_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    nat_pkg::cmd_t cmd;
    logic done;
    nat_pkg::rsp_t rsp;

    // model of the table
    logic [63:0] tbl_vals  [nat_pkg::CAPACITY];
    logic [63:0] tbl_names [nat_pkg::CAPACITY][nat_pkg::NAME_CHUNKS];
    int          tbl_count;
    logic [63:0] nm_buf [nat_pkg::NAME_CHUNKS];
    int          nm_idx;
    bit          nm_ovf;

    nat_pkg::rsp_t expected_rsp_q [$];
    name_t name_pool [$];
    int    mismatch_cnt;
    int    idle_pct;
    int    stall_cycles;
    bit    timed_out;

    named_atomic_table_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .done  (done),
        .rsp   (rsp)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic nat_pkg::rsp_t make_rsp(logic [2:0] st, int fslot, logic [63:0] val);
        nat_pkg::rsp_t r;
        r.status       = st;
        r.found_slot   = fslot[nat_pkg::SLOT_W-1:0];
        r.result_value = val;
        return r;
    endfunction

    function automatic void clear_name_buf();
        for (int i = 0; i < nat_pkg::NAME_CHUNKS; i++)
            nm_buf[i] = '0;
        nm_idx = 0;
        nm_ovf = 0;
    endfunction

    // zero everything past the terminator, return the name length in bytes
    function automatic int name_length();
        int  len;
        bit  ended;
        int  c;
        int  sh;
        len   = nat_pkg::NAME_CHUNKS * 8;
        ended = 0;
        for (int i = 0; i < nat_pkg::NAME_CHUNKS * 8; i++)
        begin
            c  = i / 8;
            sh = (i % 8) * 8;
            if (ended)
                nm_buf[c][sh +: 8] = 8'h00;
            else if (nm_buf[c][sh +: 8] == 8'h00)
            begin
                ended = 1;
                len   = i;
            end
        end
        return len;
    endfunction

    function automatic void predict_lookup(nat_pkg::cmd_t c);
        int  len;
        bit  hit;
        int  hit_slot;
        if (nm_idx < nat_pkg::NAME_CHUNKS)
        begin
            nm_buf[nm_idx] = c.name_chunk;
            nm_idx++;
        end
        else
            nm_ovf = 1;
        if (!c.chunk_last)
            return;
        len = name_length();
        if (nm_ovf || len > 55 || len >= nat_pkg::NAME_CHUNKS * 8)
        begin
            expected_rsp_q.push_back(make_rsp(nat_pkg::ST_TOO_LONG, 0, '0));
            clear_name_buf();
            return;
        end
        hit      = 0;
        hit_slot = 0;
        for (int e = 0; e < tbl_count && !hit; e++)
        begin
            hit = 1;
            for (int k = 0; k < nat_pkg::NAME_CHUNKS; k++)
                if (tbl_names[e][k] !== nm_buf[k])
                    hit = 0;
            if (hit)
                hit_slot = e;
        end
        if (hit)
            expected_rsp_q.push_back(make_rsp(nat_pkg::ST_OK, hit_slot, '0));
        else if (!c.create_if_missing)
            expected_rsp_q.push_back(make_rsp(nat_pkg::ST_NOT_FOUND, 0, '0));
        else if (tbl_count >= nat_pkg::CAPACITY)
            expected_rsp_q.push_back(make_rsp(nat_pkg::ST_FULL, 0, '0));
        else
        begin
            tbl_vals[tbl_count] = '0;
            for (int k = 0; k < nat_pkg::NAME_CHUNKS; k++)
                tbl_names[tbl_count][k] = nm_buf[k];
            expected_rsp_q.push_back(make_rsp(nat_pkg::ST_OK, tbl_count, '0));
            tbl_count++;
        end
        clear_name_buf();
    endfunction

    function automatic void predict_table_op(nat_pkg::cmd_t c);
        logic [63:0] old_val;
        logic [63:0] res;
        int          s;
        if (c.mode == nat_pkg::MODE_LOOKUP)
        begin
            predict_lookup(c);
            return;
        end
        if (c.mode > nat_pkg::MODE_CAS)
            return;
        s = int'(c.slot);
        if (s >= tbl_count)
        begin
            expected_rsp_q.push_back(make_rsp(nat_pkg::ST_BAD_SLOT, 0, '0));
            return;
        end
        old_val = tbl_vals[s];
        res     = old_val;
        case (c.mode)
            nat_pkg::MODE_XCHG: tbl_vals[s] = c.operand_value;
            nat_pkg::MODE_ADD:
            begin
                res         = old_val + c.operand_value;
                tbl_vals[s] = res;
            end
            nat_pkg::MODE_CAS:
                if (old_val == c.compare_value)
                    tbl_vals[s] = c.operand_value;
            default: ;
        endcase
        expected_rsp_q.push_back(make_rsp(nat_pkg::ST_OK, 0, res));
    endfunction

    // drive one transaction and wait for the block to take it
    task automatic send_cmd(nat_pkg::cmd_t c);
        if ($urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        start = 1'b1;
        cmd   = c;
        do
            @(posedge clk);
        while (busy);
        predict_table_op(c);
        @(negedge clk);
        start = 1'b0;
        cmd   = '{mode: cmd.mode, name_chunk: rand64(), chunk_last: 1'b0,
                  create_if_missing: 1'b0, slot: cmd.slot,
                  operand_value: cmd.operand_value, compare_value: cmd.compare_value};
    endtask

    function automatic nat_pkg::cmd_t junk_cmd();
        logic [223:0]  r;
        nat_pkg::cmd_t c;
        r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        c = r[$bits(nat_pkg::cmd_t)-1:0];
        return c;
    endfunction

    function automatic nat_pkg::cmd_t value_cmd(logic [2:0] m, int s, logic [63:0] opv,
                                                logic [63:0] cmpv);
        nat_pkg::cmd_t c;
        c               = junk_cmd();
        c.mode          = m;
        c.slot          = s[nat_pkg::SLOT_W-1:0];
        c.operand_value = opv;
        c.compare_value = cmpv;
        return c;
    endfunction

    // bytes of the name, a terminator, then zeros or garbage
    function automatic name_t make_name(int len, bit garbage, int extra);
        name_t       nm;
        logic [7:0]  b;
        for (int i = 0; i < MAX_CHUNKS * 8; i++)
        begin
            if (i < len)
                b = 8'($urandom_range(1, 255));
            else if (i == len)
                b = 8'h00;
            else
                b = garbage ? 8'($urandom) : 8'h00;
            nm.ch[i / 8][(i % 8) * 8 +: 8] = b;
        end
        nm.n = (len >= 56) ? nat_pkg::NAME_CHUNKS : len / 8 + 1;
        nm.n = nm.n + extra;
        return nm;
    endfunction

    function automatic name_t random_name();
        int len;
        int extra;
        len   = ($urandom_range(9) == 0) ? $urandom_range(56, 62) : $urandom_range(0, 55);
        extra = ($urandom_range(19) == 0) ? $urandom_range(1, 2) : 0;
        return make_name(len, $urandom_range(2) == 0, extra);
    endfunction

    // stream a name; a value transaction may be slipped in after the first chunk
    task automatic send_name(name_t nm, bit create, bit interleave);
        nat_pkg::cmd_t c;
        for (int i = 0; i < nm.n; i++)
        begin
            c                   = junk_cmd();
            c.mode              = nat_pkg::MODE_LOOKUP;
            c.name_chunk        = nm.ch[i];
            c.chunk_last        = (i == nm.n - 1);
            c.create_if_missing = c.chunk_last ? create : c.create_if_missing;
            send_cmd(c);
            if (interleave && i == 0 && nm.n > 1)
                send_cmd(value_cmd(3'($urandom_range(1, 4)),
                                   $urandom_range(0, tbl_count), rand64(), rand64()));
        end
    endtask

    task automatic test_empty_table();
        name_t nm;
        send_cmd(value_cmd(nat_pkg::MODE_READ, 0, '0, '0));
        nm = make_name(1, 0, 0);
        send_name(nm, 0, 0);
        send_name(nm, 1, 0);
        send_name(make_name(0, 0, 0), 1, 0);
        send_name(nm, 0, 0);
    endtask

    task automatic test_name_limits();
        name_t nm;
        nm = make_name(55, 1, 0);
        send_name(nm, 1, 1);
        send_name(nm, 0, 0);
        send_name(make_name(56, 0, 0), 1, 0);
        send_name(make_name(20, 0, 1), 1, 0);
        // empty name again but with garbage past the terminator
        send_name(make_name(0, 1, 0), 0, 0);
    endtask

    task automatic test_value_ops();
        send_cmd(value_cmd(nat_pkg::MODE_XCHG, 0, 64'h7fff_ffff_ffff_ffff, '0));
        send_cmd(value_cmd(nat_pkg::MODE_ADD, 0, 64'h1, '0));
        send_cmd(value_cmd(nat_pkg::MODE_ADD, 0, 64'hffff_ffff_ffff_ffff, '0));
        send_cmd(value_cmd(nat_pkg::MODE_CAS, 0, 64'h1234, 64'h8000_0000_0000_0000 - 1));
        send_cmd(value_cmd(nat_pkg::MODE_CAS, 0, 64'h8000_0000_0000_0000, 64'h1234));
        send_cmd(value_cmd(nat_pkg::MODE_READ, 0, '1, '1));
        send_cmd(value_cmd(nat_pkg::MODE_READ, 1023, '0, '0));
        send_cmd(value_cmd(nat_pkg::MODE_XCHG, tbl_count, '0, '0));
        send_cmd(value_cmd(3'd5, 0, '0, '0));
        send_cmd(value_cmd(3'd7, 1, '0, '0));
    endtask

    task automatic test_random(int n_items, int pct);
        int    r;
        int    s;
        name_t nm;
        idle_pct = pct;
        for (int i = 0; i < n_items; i++)
        begin
            r = $urandom_range(99);
            if (r < 15)
            begin
                if (name_pool.size() > 0 && $urandom_range(9) < 6)
                    nm = name_pool[$urandom_range(name_pool.size() - 1)];
                else
                begin
                    nm = random_name();
                    name_pool.push_back(nm);
                end
                send_name(nm, tbl_count < 60 ? $urandom_range(3) != 0 : 1'b0,
                          $urandom_range(7) == 0);
            end
            else if (r < 20)
                send_cmd(value_cmd(3'($urandom_range(5, 7)), $urandom_range(1023),
                                   rand64(), rand64()));
            else
            begin
                s = ($urandom_range(9) < 8 && tbl_count > 0) ?
                    $urandom_range(tbl_count - 1) : $urandom_range(1023);
                send_cmd(value_cmd(3'($urandom_range(1, 4)), s,
                                   ($urandom_range(7) == 0) ? 64'h8000_0000_0000_0000 :
                                   rand64(),
                                   ($urandom_range(1) == 0 && s < tbl_count) ?
                                   tbl_vals[s] : rand64()));
            end
        end
    endtask

    // single-chunk names keep the fill short
    task automatic test_table_full();
        idle_pct = 0;
        while (tbl_count < nat_pkg::CAPACITY)
            send_name(make_name($urandom_range(4, 7), 0, 0), 1, 0);
        send_name(make_name(30, 0, 0), 1, 0);
        send_name(make_name(30, 0, 0), 0, 0);
        send_cmd(value_cmd(nat_pkg::MODE_ADD, nat_pkg::CAPACITY - 1, 64'd5, '0));
        send_cmd(value_cmd(nat_pkg::MODE_READ, 1023, '0, '0));
    endtask

    // response checker
    always @(posedge clk)
    begin
        nat_pkg::rsp_t exp_rsp;
        if (rst_n && done)
        begin
            if (expected_rsp_q.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected response: status %0d slot %0d value %h",
                             rsp.status, rsp.found_slot, rsp.result_value);
            end
            else
            begin
                exp_rsp = expected_rsp_q.pop_front();
                if (rsp.status !== exp_rsp.status || rsp.found_slot !== exp_rsp.found_slot
                    || rsp.result_value !== exp_rsp.result_value)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("response mismatch: exp %0d/%0d/%h got %0d/%0d/%h",
                                 exp_rsp.status, exp_rsp.found_slot, exp_rsp.result_value,
                                 rsp.status, rsp.found_slot, rsp.result_value);
                end
            end
        end
    end

    // watchdog on cycles with no transaction either way
    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1;
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        cmd          = '0;
        mismatch_cnt = 0;
        idle_pct     = 0;
        stall_cycles = 0;
        timed_out    = 0;
        tbl_count    = 0;
        clear_name_buf();
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_table();
        test_name_limits();
        test_value_ops();
        test_random(130, 0);
        test_random(130, 77);
        test_random(130, 38);
        test_random(80, 0);
        test_table_full();

        while (expected_rsp_q.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
